// ----- src/ise_pkg.sv -----
package ise_pkg;

  // field widths fixed by the port list
  localparam int unsigned CmdW      = 3;
  localparam int unsigned DepthW    = 4;
  localparam int unsigned PortWordW = 32;
  localparam int unsigned CountW    = 5;
  localparam int unsigned ErrW      = 2;

  // default sizes
  localparam int unsigned DefStackDepth = 16;
  localparam int unsigned DefWordWidth  = 32;

  // command codes
  localparam logic [CmdW-1:0] CmdPush   = 3'd0;
  localparam logic [CmdW-1:0] CmdPop    = 3'd1;
  localparam logic [CmdW-1:0] CmdPeek   = 3'd2;
  localparam logic [CmdW-1:0] CmdRemove = 3'd3;
  localparam logic [CmdW-1:0] CmdSwap   = 3'd4;

  // error codes
  localparam logic [ErrW-1:0] ErrOk    = 2'd0;
  localparam logic [ErrW-1:0] ErrEmpty = 2'd1;
  localparam logic [ErrW-1:0] ErrFull  = 2'd2;
  localparam logic [ErrW-1:0] ErrRange = 2'd3;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic              push;
    logic              shift_up;
    logic [DepthW-1:0] up_from;
    logic              swap;
    logic [DepthW-1:0] depth_a;
    logic [DepthW-1:0] depth_b;
  } cell_ctrl_t;

endpackage

// ----- src/ise_cell.sv -----
module ise_cell
  import ise_pkg::*;
#(
  parameter int unsigned WORD_WIDTH = DefWordWidth,
  parameter int unsigned CELL_IDX   = 0
) (
  input  logic                  clk_i,
  input  cell_ctrl_t            ctrl_i,
  input  logic [WORD_WIDTH-1:0] above_i,
  input  logic [WORD_WIDTH-1:0] below_i,
  input  logic [WORD_WIDTH-1:0] bus_a_i,
  input  logic [WORD_WIDTH-1:0] bus_b_i,
  output logic [WORD_WIDTH-1:0] word_o,
  output logic [WORD_WIDTH-1:0] tap_a_o,
  output logic [WORD_WIDTH-1:0] tap_b_o
);

  logic [WORD_WIDTH-1:0] word_q, word_d;
  logic                  match_a, match_b, at_or_below;

  // position compares against this cell's depth
  assign match_a     = (32'(ctrl_i.depth_a) == 32'(CELL_IDX));
  assign match_b     = (32'(ctrl_i.depth_b) == 32'(CELL_IDX));
  assign at_or_below = (32'(CELL_IDX) >= 32'(ctrl_i.up_from));

  // next word: shift down, shift up, swap exchange or hold
  always_comb begin
    priority if (ctrl_i.push) begin
      word_d = above_i;
    end else if (ctrl_i.shift_up && at_or_below) begin
      word_d = below_i;
    end else if (ctrl_i.swap && match_a) begin
      word_d = bus_b_i;
    end else if (ctrl_i.swap && match_b) begin
      word_d = bus_a_i;
    end else begin
      word_d = word_q;
    end
  end

  // data storage, no reset
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  // taps onto the shared read buses
  assign word_o  = word_q;
  assign tap_a_o = match_a ? word_q : '0;
  assign tap_b_o = match_b ? word_q : '0;

endmodule

// ----- src/indexed_stack_engine_top.sv -----
// Indexed stack engine: LIFO of words held in a chain of cells, top in cell 0.
// The result is registered and is valid in the cycle after the request is accepted.
// Throughput: one request per cycle unless a pending result is stalled; every command updates
// all cells together, and a single output register holds the result while a new request enters.
// Reset clears the word count and the output valid flag; cell words are not reset.
module indexed_stack_engine_top
  import ise_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = DefStackDepth,
  parameter int unsigned WORD_WIDTH  = DefWordWidth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [CmdW-1:0]      cmd_i,
  input  logic [PortWordW-1:0] push_value_i,
  input  logic [DepthW-1:0]    depth_a_i,
  input  logic [DepthW-1:0]    depth_b_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [PortWordW-1:0] read_value_o,
  output logic [CountW-1:0]    entry_count_o,
  output logic [ErrW-1:0]      error_code_o
);

  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned CmpW  = (CntW > DepthW) ? CntW : DepthW;
  localparam int unsigned ConvW = (WORD_WIDTH > PortWordW) ? WORD_WIDTH : PortWordW;
  localparam int unsigned OutCW = (CntW > CountW) ? CntW : CountW;

  logic                  in_acc;
  logic [CntW-1:0]       count_q, count_d;
  logic                  out_valid_q;
  logic [PortWordW-1:0]  res_read_q, res_read_d;
  logic [CntW-1:0]       res_count_q;
  logic [ErrW-1:0]       res_err_q, res_err_d;
  logic [ConvW-1:0]      push_wide, read_wide;
  logic [WORD_WIDTH-1:0] push_word, read_word;
  logic [OutCW-1:0]      count_wide;
  logic                  is_empty, is_full, a_ok, b_ok;
  cell_ctrl_t            ctrl;

  logic [WORD_WIDTH-1:0] cell_word [STACK_DEPTH];
  logic [WORD_WIDTH-1:0] tap_a     [STACK_DEPTH];
  logic [WORD_WIDTH-1:0] tap_b     [STACK_DEPTH];
  logic [WORD_WIDTH-1:0] bus_a, bus_b;

  // handshake: output register frees up when taken
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  // port word to stored word
  assign push_wide = ConvW'(push_value_i);
  assign push_word = push_wide[WORD_WIDTH-1:0];

  // status compares
  assign is_empty = (count_q == '0);
  assign is_full  = (count_q == CntW'(STACK_DEPTH));
  assign a_ok     = (CmpW'(depth_a_i) < CmpW'(count_q));
  assign b_ok     = (CmpW'(depth_b_i) < CmpW'(count_q));

  // read buses from the cell taps
  always_comb begin
    bus_a = '0;
    bus_b = '0;
    for (int k = 0; k < STACK_DEPTH; k++) begin
      bus_a = bus_a | tap_a[k];
      bus_b = bus_b | tap_b[k];
    end
  end

  // command decode
  always_comb begin
    ctrl          = '0;
    ctrl.depth_a  = depth_a_i;
    ctrl.depth_b  = depth_b_i;
    count_d       = count_q;
    read_word     = '0;
    res_err_d     = ErrOk;
    unique case (cmd_i)
      CmdPush: begin
        if (is_full) begin
          res_err_d = ErrFull;
        end else begin
          ctrl.push = in_acc;
          count_d   = count_q + 1'b1;
        end
      end
      CmdPop: begin
        if (is_empty) begin
          res_err_d = ErrEmpty;
        end else begin
          ctrl.shift_up = in_acc;
          ctrl.up_from  = '0;
          read_word     = cell_word[0];
          count_d       = count_q - 1'b1;
        end
      end
      CmdPeek, CmdRemove: begin
        if (is_empty) begin
          res_err_d = ErrEmpty;
        end else if (!a_ok) begin
          res_err_d = ErrRange;
        end else begin
          read_word = bus_a;
          if (cmd_i == CmdRemove) begin
            ctrl.shift_up = in_acc;
            ctrl.up_from  = depth_a_i;
            count_d       = count_q - 1'b1;
          end
        end
      end
      CmdSwap: begin
        if (is_empty) begin
          res_err_d = ErrEmpty;
        end else if (!a_ok || !b_ok) begin
          res_err_d = ErrRange;
        end else begin
          ctrl.swap = in_acc;
        end
      end
      default: begin
      end
    endcase
  end

  assign read_wide  = ConvW'(read_word);
  assign res_read_d = read_wide[PortWordW-1:0];

  // chain of cells, top at index 0
  for (genvar k = 0; k < STACK_DEPTH; k++) begin : g_cell
    logic [WORD_WIDTH-1:0] above, below;
    if (k == 0) begin : g_top
      assign above = push_word;
    end else begin : g_mid
      assign above = cell_word[k-1];
    end
    if (k == STACK_DEPTH - 1) begin : g_last
      assign below = cell_word[k];
    end else begin : g_inner
      assign below = cell_word[k+1];
    end
    ise_cell #(
      .WORD_WIDTH (WORD_WIDTH),
      .CELL_IDX   (k)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .above_i (above),
      .below_i (below),
      .bus_a_i (bus_a),
      .bus_b_i (bus_b),
      .word_o  (cell_word[k]),
      .tap_a_o (tap_a[k]),
      .tap_b_o (tap_b[k])
    );
  end

  // count and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_read_q  <= res_read_d;
      res_count_q <= count_d;
      res_err_q   <= res_err_d;
    end
  end

  assign count_wide    = OutCW'(res_count_q);
  assign out_valid_o   = out_valid_q;
  assign read_value_o  = res_read_q;
  assign entry_count_o = count_wide[CountW-1:0];
  assign error_code_o  = res_err_q;

  // count never passes the stack depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= 32'(STACK_DEPTH))
    else $error("count beyond stack depth");

  // a good push adds one word
  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && cmd_i == CmdPush && !is_full) |=> count_q == $past(count_q) + 1'b1)
    else $error("push did not add one word");

  // a failed request leaves the count alone
  a_err_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && res_err_d != ErrOk) |=> count_q == $past(count_q))
    else $error("failed request changed the count");

  // a pending result reports the live count
  a_count_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> res_count_q == count_q)
    else $error("reported count differs from held count");

endmodule

// ----- dv/indexed_stack_engine_top_tb.sv -----
`timescale 1ns / 100ps

import ise_pkg::*;

// one result as it leaves the block
typedef struct packed {
  logic [PortWordW-1:0] read_value;
  logic [CountW-1:0]    entry_count;
  logic [ErrW-1:0]      error_code;
} stack_result_t;

// shadow stack plus the queue of results still owed by the block
class stack_scoreboard;
  logic [PortWordW-1:0] held_words[$];  // depth 0 at index 0
  stack_result_t        owed_results[$];
  int unsigned          failures;
  int unsigned          checked;
  int unsigned          noted;
  int unsigned          err_hits[4];

  // apply one accepted request to the shadow stack and queue its result
  function void note_request(logic [CmdW-1:0] cmd, logic [PortWordW-1:0] value,
                             logic [DepthW-1:0] depth_a, logic [DepthW-1:0] depth_b);
    stack_result_t        res;
    logic [PortWordW-1:0] tmp;
    int unsigned          held;
    held = held_words.size();
    res  = '0;
    case (cmd)
      CmdPush: begin
        if (held >= DefStackDepth) res.error_code = ErrFull;
        else held_words.push_front(value);
      end
      CmdPop: begin
        if (held == 0) res.error_code = ErrEmpty;
        else res.read_value = held_words.pop_front();
      end
      CmdPeek, CmdRemove: begin
        if (held == 0) begin
          res.error_code = ErrEmpty;
        end else if (depth_a >= held) begin
          res.error_code = ErrRange;
        end else begin
          res.read_value = held_words[depth_a];
          // words below the removed one close the gap
          if (cmd == CmdRemove) held_words.delete(depth_a);
        end
      end
      CmdSwap: begin
        if (held == 0) begin
          res.error_code = ErrEmpty;
        end else if (depth_a >= held || depth_b >= held) begin
          res.error_code = ErrRange;
        end else begin
          tmp                 = held_words[depth_a];
          held_words[depth_a] = held_words[depth_b];
          held_words[depth_b] = tmp;
        end
      end
      default: ;  // unused codes leave everything alone
    endcase
    res.entry_count = CountW'(held_words.size());
    err_hits[res.error_code]++;
    owed_results.push_back(res);
    noted++;
  endfunction

  // compare one delivered result with the oldest owed one
  function void check_result(logic [PortWordW-1:0] read_value, logic [CountW-1:0] entry_count,
                             logic [ErrW-1:0] error_code);
    stack_result_t want;
    if (owed_results.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("unexpected result: read %h count %0d err %0d",
                 read_value, entry_count, error_code);
      return;
    end
    want = owed_results.pop_front();
    checked++;
    if (read_value !== want.read_value || entry_count !== want.entry_count ||
        error_code !== want.error_code) begin
      failures++;
      if (failures <= 10)
        $display("mismatch on result %0d: read %h/%h count %0d/%0d err %0d/%0d (exp/got)",
                 checked, want.read_value, read_value, want.entry_count, entry_count,
                 want.error_code, error_code);
    end
  endfunction
endclass

module indexed_stack_engine_top_tb;

  logic                 clk          = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_ready_o;
  logic [CmdW-1:0]      cmd_i        = CmdPush;
  logic [PortWordW-1:0] push_value_i = '0;
  logic [DepthW-1:0]    depth_a_i    = '0;
  logic [DepthW-1:0]    depth_b_i    = '0;
  logic                 out_valid_o;
  logic                 out_ready_i  = 1'b0;
  logic [PortWordW-1:0] read_value_o;
  logic [CountW-1:0]    entry_count_o;
  logic [ErrW-1:0]      error_code_o;

  localparam logic [CmdW-1:0] CmdLastCode = {CmdW{1'b1}};
  localparam int unsigned     HoldCycles  = 80;

  stack_scoreboard sb;
  int unsigned     results_seen = 0;
  int unsigned     tx_quiet     = 0;
  bit              long_hold_done = 1'b0;

  indexed_stack_engine_top uut (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .push_value_i  (push_value_i),
    .depth_a_i     (depth_a_i),
    .depth_b_i     (depth_b_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .read_value_o  (read_value_o),
    .entry_count_o (entry_count_o),
    .error_code_o  (error_code_o)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // idle length: mostly short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  // present one request from a falling edge and hold it until taken
  task automatic send_request(input logic [CmdW-1:0] cmd, input logic [PortWordW-1:0] value,
                              input logic [DepthW-1:0] depth_a,
                              input logic [DepthW-1:0] depth_b);
    in_valid_i   <= 1'b1;
    cmd_i        <= cmd;
    push_value_i <= value;
    depth_a_i    <= depth_a;
    depth_b_i    <= depth_b;
    @(posedge clk);
    while (!in_ready_o) @(posedge clk);
    @(negedge clk);
  endtask

  // request followed by a random sender gap
  task automatic issue(input logic [CmdW-1:0] cmd, input logic [PortWordW-1:0] value,
                       input logic [DepthW-1:0] depth_a, input logic [DepthW-1:0] depth_b);
    int unsigned gap;
    send_request(cmd, value, depth_a, depth_b);
    if (tx_quiet > 0) begin
      tx_quiet--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 199) == 0) tx_quiet = 60;
      gap = idle_len();
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // random traffic that sweeps the stack between empty and full
  task automatic run_random(input int unsigned n_items);
    int unsigned          issued;
    int unsigned          held;
    int unsigned          r;
    bit                   filling;
    logic [CmdW-1:0]      cmd;
    logic [PortWordW-1:0] value;
    logic [DepthW-1:0]    depth_a;
    logic [DepthW-1:0]    depth_b;
    issued  = 0;
    filling = 1'b1;
    while (issued < n_items) begin
      held = sb.held_words.size();
      if (held == DefStackDepth) filling = 1'b0;
      else if (held == 0) filling = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 3) cmd = CmdW'($urandom_range(CmdSwap + 1, CmdLastCode));
      else if (r < 45) cmd = filling ? CmdPush : ($urandom_range(0, 1) ? CmdPop : CmdRemove);
      else cmd = CmdW'($urandom_range(CmdPush, CmdSwap));
      // mostly legal depths, some anywhere in the field
      if (held > 0 && $urandom_range(0, 9) < 8)
        depth_a = DepthW'($urandom_range(0, held - 1));
      else
        depth_a = DepthW'($urandom);
      if (held > 0 && $urandom_range(0, 9) < 8)
        depth_b = DepthW'($urandom_range(0, held - 1));
      else
        depth_b = DepthW'($urandom);
      r = $urandom_range(0, 9);
      if (r == 0) value = '0;
      else if (r == 1) value = '1;
      else value = $urandom;
      issue(cmd, value, depth_a, depth_b);
      if (cmd <= CmdSwap) issued++;
    end
  endtask

  // sample both channels at the rising edge
  always @(posedge clk) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        sb.note_request(cmd_i, push_value_i, depth_a_i, depth_b_i);
      if (out_valid_o && out_ready_i) begin
        sb.check_result(read_value_o, entry_count_o, error_code_o);
        results_seen++;
      end
    end
  end

  // result receiver with random stalls and one long hold-off
  initial begin : result_sink
    int unsigned stall;
    int unsigned last_seen;
    int unsigned quiet;
    stall     = 0;
    last_seen = 0;
    quiet     = 0;
    forever begin
      @(negedge clk);
      if (rst_ni && !long_hold_done && results_seen >= 400) begin
        // long back-pressure so the block fills and stalls its input
        long_hold_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        last_seen = results_seen;
        stall     = 0;
      end else begin
        if (results_seen != last_seen) begin
          last_seen = results_seen;
          if (quiet > 0) begin
            quiet--;
            stall = 0;
          end else begin
            if ($urandom_range(0, 199) == 0) quiet = 60;
            stall = idle_len();
          end
        end
        if (stall > 0) begin
          out_ready_i <= 1'b0;
          stall--;
        end else begin
          out_ready_i <= 1'b1;
        end
      end
    end
  end

  // main sequence
  initial begin : stimulus
    int unsigned cycles;
    int unsigned leftover;
    sb = new();
    repeat (4) @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    // empty stack
    issue(CmdPop, '0, '0, '0);
    issue(CmdSwap, '0, '0, '0);
    // fill to the brim, extremes first
    for (int i = 0; i < DefStackDepth; i++)
      issue(CmdPush, (i == 0) ? 32'h0 : ((i == 1) ? 32'hFFFF_FFFF : $urandom), '0, '0);
    // push when full
    issue(CmdPush, 32'hA5A5_5A5A, '0, '0);
    // swap top and bottom, then indexed reads
    issue(CmdSwap, '0, 4'd15, 4'd0);
    issue(CmdPeek, '0, 4'd5, '0);
    issue(CmdRemove, '0, 4'd15, '0);
    issue(CmdRemove, '0, 4'd0, '0);
    // depth at count is out of range
    issue(CmdPeek, '0, 4'd14, '0);
    // swap with itself, then with one depth out of range
    issue(CmdSwap, '0, 4'd3, 4'd3);
    issue(CmdSwap, '0, 4'd0, 4'd14);
    // unused command code
    issue(CmdLastCode, 32'hFFFF_FFFF, 4'd15, 4'd15);
    issue(CmdPop, '0, '0, '0);

    run_random(1200);
    in_valid_i <= 1'b0;

    // drain, then allow the pipeline to settle
    cycles = 0;
    while (sb.owed_results.size() != 0 && cycles < 4000) begin
      @(posedge clk);
      cycles++;
    end
    repeat (6) @(posedge clk);

    leftover = sb.owed_results.size();
    if (leftover != 0) $display("%0d results never arrived", leftover);
    $display("%0d requests run: %0d ok, %0d on empty, %0d on full, %0d depth out of range",
             sb.noted, sb.err_hits[ErrOk], sb.err_hits[ErrEmpty], sb.err_hits[ErrFull],
             sb.err_hits[ErrRange]);
    $display("%0d results compared, %0d failures, long output hold-off %0s",
             sb.checked, sb.failures, long_hold_done ? "applied" : "not reached");
    if (sb.failures == 0 && leftover == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #5_000_000;
    $display("timeout waiting on the block");
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/ise_pkg.sv
src/ise_cell.sv
src/indexed_stack_engine_top.sv
dv/indexed_stack_engine_top_tb.sv
